[sv/assert_macros.svh]
// Assertion macros used by the top RTL file of the keyed node cache table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define KN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define KN_ASSERT_IMP(lbl, ante, cons)

`define KN_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[sv/kncache_pkg.sv]
// Package with widths, field offsets, operation and status codes of the node cache table.
package kncache_pkg;

  localparam int DEF_ENTRIES      = 16;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam int OWNER_W   = 16;
  localparam int INODE_W   = 32;
  localparam int REFS_W    = 8;
  localparam int PORT_PL_W = 64;
  localparam int SLOT_W    = 4;
  localparam int FREED_W   = 5;

  localparam int IN_OP_LSB    = 0;
  localparam int IN_OWNER_LSB = 2;
  localparam int IN_INODE_LSB = 18;
  localparam int IN_PL_LSB    = 50;
  localparam int IN_W         = 120;

  localparam int OUT_STAT_LSB  = 0;
  localparam int OUT_SLOT_LSB  = 2;
  localparam int OUT_PL_LSB    = 6;
  localparam int OUT_FREED_LSB = 70;
  localparam int OUT_USED_W    = 75;
  localparam int OUT_W         = 80;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_MISS   = 2'd1;
  localparam logic [1:0] STAT_CACHED = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  typedef struct packed {
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } kncache_cmd_t;

endpackage

[sv/kncache_store.sv]
// Entry storage: key, count and payload memories with a registered read port, plus valid bits.
module kncache_store #(
  parameter int ENTRIES = 16,
  parameter int PAYLOAD_BITS = 64,
  localparam int IDXW = $clog2(ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [IDXW-1:0]               rd_addr,
  output logic [kncache_pkg::OWNER_W-1:0] rd_owner,
  output logic [kncache_pkg::INODE_W-1:0] rd_inode,
  output logic [kncache_pkg::REFS_W-1:0]  rd_refs,
  output logic [PAYLOAD_BITS-1:0]       rd_payload,
  input  kncache_pkg::kncache_cmd_t     cmd,
  input  logic [IDXW-1:0]               wr_addr,
  input  logic [kncache_pkg::OWNER_W-1:0] wr_owner,
  input  logic [kncache_pkg::INODE_W-1:0] wr_inode,
  input  logic [kncache_pkg::REFS_W-1:0]  wr_refs,
  input  logic [PAYLOAD_BITS-1:0]       wr_payload,
  output logic [ENTRIES-1:0]            valid
);
  import kncache_pkg::*;

  logic [OWNER_W-1:0]      mem_owner   [ENTRIES];
  logic [INODE_W-1:0]      mem_inode   [ENTRIES];
  logic [REFS_W-1:0]       mem_refs    [ENTRIES];
  logic [PAYLOAD_BITS-1:0] mem_payload [ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_owner[wr_addr]   <= wr_owner;
      mem_inode[wr_addr]   <= wr_inode;
      mem_refs[wr_addr]    <= wr_refs;
      mem_payload[wr_addr] <= wr_payload;
    end
    rd_owner   <= mem_owner[rd_addr];
    rd_inode   <= mem_inode[rd_addr];
    rd_refs    <= mem_refs[rd_addr];
    rd_payload <= mem_payload[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.set_valid) begin
      valid[wr_addr] <= 1'b1;
    end else if (cmd.clr_valid) begin
      valid[wr_addr] <= 1'b0;
    end
  end

endmodule

[sv/kncache_ctrl.sv]
// Sequencer that sweeps the entries through one key compare unit and updates the table.
module kncache_ctrl #(
  parameter int ENTRIES = 16,
  parameter int PAYLOAD_BITS = 64,
  localparam int IDXW = $clog2(ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [kncache_pkg::OWNER_W-1:0] in_owner,
  input  logic [kncache_pkg::INODE_W-1:0] in_inode,
  input  logic [PAYLOAD_BITS-1:0]         in_payload,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [1:0]                      res_status,
  output logic [kncache_pkg::SLOT_W-1:0]  res_slot_out,
  output logic [kncache_pkg::PORT_PL_W-1:0] res_payload_out,
  output logic [kncache_pkg::FREED_W-1:0] res_freed,
  output logic [IDXW-1:0]                 rd_addr,
  input  logic [kncache_pkg::OWNER_W-1:0] rd_owner,
  input  logic [kncache_pkg::INODE_W-1:0] rd_inode,
  input  logic [kncache_pkg::REFS_W-1:0]  rd_refs,
  input  logic [PAYLOAD_BITS-1:0]         rd_payload,
  output kncache_pkg::kncache_cmd_t       cmd,
  output logic [IDXW-1:0]                 wr_addr,
  output logic [kncache_pkg::OWNER_W-1:0] wr_owner,
  output logic [kncache_pkg::INODE_W-1:0] wr_inode,
  output logic [kncache_pkg::REFS_W-1:0]  wr_refs,
  output logic [PAYLOAD_BITS-1:0]         wr_payload,
  input  logic [ENTRIES-1:0]              valid
);
  import kncache_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [IDXW-1:0] LAST = IDXW'(ENTRIES - 1);
  localparam logic [FREED_W-1:0] FREED_MAX = '1;

  logic [1:0]              state, state_next;
  logic [1:0]              op, op_next;
  logic [OWNER_W-1:0]      owner, owner_next;
  logic [INODE_W-1:0]      inode, inode_next;
  logic [PAYLOAD_BITS-1:0] payload, payload_next;
  logic [IDXW-1:0]         cnt, cnt_next;
  logic                    issue_on, issue_on_next;
  logic                    probe_live, probe_live_next;
  logic [IDXW-1:0]         probe_idx, probe_idx_next;
  logic                    free_found, free_found_next;
  logic [IDXW-1:0]         free_idx, free_idx_next;
  logic [1:0]              status, status_next;
  logic [IDXW-1:0]         slot, slot_next;
  logic [PAYLOAD_BITS-1:0] res_pl, res_pl_next;
  logic [FREED_W-1:0]      freed, freed_next;

  logic owner_eq, key_hit, own_hit, slot_free, probe_last;

  assign owner_eq   = rd_owner == owner;
  assign key_hit    = probe_live && valid[probe_idx] && owner_eq && rd_inode == inode;
  assign own_hit    = probe_live && valid[probe_idx] && owner_eq;
  assign slot_free  = probe_live && !valid[probe_idx];
  assign probe_last = probe_live && probe_idx == LAST;

  assign in_ready        = state == S_IDLE;
  assign res_valid       = state == S_FIN;
  assign res_status      = status;
  assign res_slot_out    = SLOT_W'(slot);
  assign res_payload_out = PORT_PL_W'(res_pl);
  assign res_freed       = freed;
  assign rd_addr         = cnt;

  always_comb begin
    state_next      = state;
    op_next         = op;
    owner_next      = owner;
    inode_next      = inode;
    payload_next    = payload;
    cnt_next        = cnt;
    issue_on_next   = issue_on;
    probe_live_next = probe_live;
    probe_idx_next  = probe_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    status_next     = status;
    slot_next       = slot;
    res_pl_next     = res_pl;
    freed_next      = freed;
    cmd             = '0;
    wr_addr         = probe_idx;
    wr_owner        = rd_owner;
    wr_inode        = rd_inode;
    wr_refs         = rd_refs;
    wr_payload      = rd_payload;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next         = in_op;
          owner_next      = in_owner;
          inode_next      = in_inode;
          payload_next    = in_payload;
          cnt_next        = '0;
          issue_on_next   = 1'b1;
          probe_live_next = 1'b0;
          free_found_next = 1'b0;
          status_next     = STAT_OK;
          slot_next       = '0;
          res_pl_next     = '0;
          freed_next      = '0;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        probe_live_next = issue_on;
        probe_idx_next  = cnt;
        if (issue_on) begin
          cnt_next = cnt + 1'b1;
          if (cnt == LAST) begin
            issue_on_next = 1'b0;
          end
        end
        if (op == OP_CLEAR) begin
          if (own_hit) begin
            cmd.clr_valid = 1'b1;
            if (freed != FREED_MAX) begin
              freed_next = freed + 1'b1;
            end
          end
          if (probe_last) begin
            state_next = S_FIN;
          end
        end else if (key_hit) begin
          slot_next  = probe_idx;
          state_next = S_FIN;
          case (op)
            OP_LOOKUP: begin
              res_pl_next = rd_payload;
            end
            OP_INSERT: begin
              status_next = STAT_CACHED;
              res_pl_next = rd_payload;
            end
            default: begin
              if (rd_refs <= REFS_W'(1)) begin
                cmd.clr_valid = 1'b1;
                freed_next    = FREED_W'(1);
              end else begin
                cmd.wr_en = 1'b1;
                wr_refs   = rd_refs - 1'b1;
              end
            end
          endcase
        end else begin
          if (slot_free && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = probe_idx;
          end
          if (probe_last) begin
            state_next = S_FIN;
            if (op == OP_INSERT) begin
              if (free_found || slot_free) begin
                wr_addr       = free_found ? free_idx : probe_idx;
                cmd.wr_en     = 1'b1;
                cmd.set_valid = 1'b1;
                wr_owner      = owner;
                wr_inode      = inode;
                wr_refs       = REFS_W'(1);
                wr_payload    = payload;
                slot_next     = wr_addr;
              end else begin
                status_next = STAT_FULL;
              end
            end else begin
              status_next = STAT_MISS;
            end
          end
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_on   <= 1'b0;
      probe_live <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state      <= state_next;
      issue_on   <= issue_on_next;
      probe_live <= probe_live_next;
      free_found <= free_found_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    owner     <= owner_next;
    inode     <= inode_next;
    payload   <= payload_next;
    cnt       <= cnt_next;
    probe_idx <= probe_idx_next;
    free_idx  <= free_idx_next;
    status    <= status_next;
    slot      <= slot_next;
    res_pl    <= res_pl_next;
    freed     <= freed_next;
  end

endmodule

[sv/keyed_node_cache_table.sv]
// A key found in entry k answers once its compare hits; a miss, an insert of a new key
// and a clear sweep every entry before they answer. One word is taken at a time, the
// next only once the answer has moved to the output register. One key compare unit
// walks the single read port of the entry memory one entry per cycle.
// Reset clears the sequencer, the output valid flag and all entry valid bits at once.
`include "assert_macros.svh"

module keyed_node_cache_table #(
  parameter int ENTRIES = kncache_pkg::DEF_ENTRIES,
  parameter int PAYLOAD_BITS = kncache_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // operation, owner_handle, inode_number, node_payload (lowest bit first)
  input  logic [kncache_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status, slot_index, payload_out, freed_count (lowest bit first)
  output logic [kncache_pkg::OUT_W-1:0] m_axis_tdata
);
  import kncache_pkg::*;

  localparam int IDXW = $clog2(ENTRIES);

  logic                 res_valid, res_ready;
  logic [1:0]           res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [PORT_PL_W-1:0] res_payload;
  logic [FREED_W-1:0]   res_freed;

  logic [IDXW-1:0]         rd_addr, wr_addr;
  logic [OWNER_W-1:0]      rd_owner, wr_owner;
  logic [INODE_W-1:0]      rd_inode, wr_inode;
  logic [REFS_W-1:0]       rd_refs, wr_refs;
  logic [PAYLOAD_BITS-1:0] rd_payload, wr_payload;
  kncache_cmd_t            cmd;
  logic [ENTRIES-1:0]      valid;

  kncache_ctrl #(
    .ENTRIES(ENTRIES),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_op(s_axis_tdata[IN_OP_LSB +: 2]),
    .in_owner(s_axis_tdata[IN_OWNER_LSB +: OWNER_W]),
    .in_inode(s_axis_tdata[IN_INODE_LSB +: INODE_W]),
    .in_payload(s_axis_tdata[IN_PL_LSB +: PAYLOAD_BITS]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_status(res_status),
    .res_slot_out(res_slot),
    .res_payload_out(res_payload),
    .res_freed(res_freed),
    .rd_addr(rd_addr),
    .rd_owner(rd_owner),
    .rd_inode(rd_inode),
    .rd_refs(rd_refs),
    .rd_payload(rd_payload),
    .cmd(cmd),
    .wr_addr(wr_addr),
    .wr_owner(wr_owner),
    .wr_inode(wr_inode),
    .wr_refs(wr_refs),
    .wr_payload(wr_payload),
    .valid(valid)
  );

  kncache_store #(
    .ENTRIES(ENTRIES),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .rd_addr(rd_addr),
    .rd_owner(rd_owner),
    .rd_inode(rd_inode),
    .rd_refs(rd_refs),
    .rd_payload(rd_payload),
    .cmd(cmd),
    .wr_addr(wr_addr),
    .wr_owner(wr_owner),
    .wr_inode(wr_inode),
    .wr_refs(wr_refs),
    .wr_payload(wr_payload),
    .valid(valid)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {(OUT_W - OUT_USED_W)'(0), res_freed, res_payload, res_slot, res_status};
    end
  end

  `KN_ASSERT_NXT(a_one_op_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `KN_ASSERT_IMP(a_miss_fields_zero, m_axis_tvalid && (m_axis_tdata[OUT_STAT_LSB +: 2] == STAT_MISS || m_axis_tdata[OUT_STAT_LSB +: 2] == STAT_FULL), m_axis_tdata[OUT_FREED_LSB - 1:OUT_SLOT_LSB] == '0 && m_axis_tdata[OUT_FREED_LSB +: FREED_W] == '0)
  `KN_ASSERT_IMP(a_freed_only_ok, m_axis_tvalid && m_axis_tdata[OUT_FREED_LSB +: FREED_W] != '0, m_axis_tdata[OUT_STAT_LSB +: 2] == STAT_OK)

endmodule

[dv/keyed_node_cache_table_tb.sv]
// Self-checking testbench for the keyed node cache table with its own table predictor.
module keyed_node_cache_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kncache_pkg::*;

  localparam int SLOTS           = DEF_ENTRIES;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_PRINTED     = 40;

  typedef struct packed {
    logic [1:0]           status;
    logic [SLOT_W-1:0]    slot;
    logic [PORT_PL_W-1:0] payload;
    logic [FREED_W-1:0]   freed;
  } node_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;

  logic                 slot_valid   [SLOTS];
  logic [OWNER_W-1:0]   slot_owner   [SLOTS];
  logic [INODE_W-1:0]   slot_inode   [SLOTS];
  logic [REFS_W-1:0]    slot_refs    [SLOTS];
  logic [PORT_PL_W-1:0] slot_payload [SLOTS];

  node_reply_t pending_replies[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          hold_request = 0;

  keyed_node_cache_table #(
    .ENTRIES(SLOTS),
    .PAYLOAD_BITS(DEF_PAYLOAD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic node_reply_t apply_node_op(input logic [1:0] op,
                                                input logic [OWNER_W-1:0] owner,
                                                input logic [INODE_W-1:0] inode,
                                                input logic [PORT_PL_W-1:0] payload);
    node_reply_t rep;
    int hit;
    int free_slot;
    rep = '0;
    rep.status = STAT_OK;
    hit = -1;
    free_slot = -1;
    // Scan downward so the lowest matching and lowest free slot win.
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_owner[i] == owner && slot_inode[i] == inode) hit = i;
      if (!slot_valid[i]) free_slot = i;
    end
    case (op)
      OP_LOOKUP: begin
        if (hit < 0) begin
          rep.status = STAT_MISS;
        end else begin
          rep.slot = hit[SLOT_W-1:0];
          rep.payload = slot_payload[hit];
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          rep.status = STAT_CACHED;
          rep.slot = hit[SLOT_W-1:0];
          rep.payload = slot_payload[hit];
        end else if (free_slot < 0) begin
          rep.status = STAT_FULL;
        end else begin
          slot_valid[free_slot] = 1'b1;
          slot_owner[free_slot] = owner;
          slot_inode[free_slot] = inode;
          slot_refs[free_slot] = REFS_W'(1);
          slot_payload[free_slot] = payload;
          rep.slot = free_slot[SLOT_W-1:0];
        end
      end
      OP_RELEASE: begin
        if (hit < 0) begin
          rep.status = STAT_MISS;
        end else begin
          rep.slot = hit[SLOT_W-1:0];
          if (slot_refs[hit] <= REFS_W'(1)) begin
            slot_valid[hit] = 1'b0;
            slot_refs[hit] = '0;
            rep.freed = FREED_W'(1);
          end else begin
            slot_refs[hit] = slot_refs[hit] - 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_owner[i] == owner) begin
            slot_valid[i] = 1'b0;
            slot_refs[i] = '0;
            if (rep.freed != '1) rep.freed = rep.freed + 1'b1;
          end
        end
      end
    endcase
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic send_request(input logic [1:0] op, input logic [OWNER_W-1:0] owner,
                              input logic [INODE_W-1:0] inode,
                              input logic [PORT_PL_W-1:0] payload);
    logic [IN_W-1:0] word;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    word = '0;
    word[IN_OP_LSB +: 2] = op;
    word[IN_OWNER_LSB +: OWNER_W] = owner;
    word[IN_INODE_LSB +: INODE_W] = inode;
    word[IN_PL_LSB +: PORT_PL_W] = payload;
    s_axis_tdata <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_replies.push_back(apply_node_op(op, owner, inode, payload));
  endtask

  task automatic drain_replies;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_ops;
    send_request(OP_INSERT, '0, '0, '0);
    send_request(OP_INSERT, '1, '1, '1);
    send_request(OP_INSERT, '1, '1, {$urandom, $urandom});
    send_request(OP_LOOKUP, '1, '1, {$urandom, $urandom});
    // Same inode under a different owner must not match.
    send_request(OP_LOOKUP, '0, '1, {$urandom, $urandom});
    send_request(OP_RELEASE, '0, '0, {$urandom, $urandom});
    send_request(OP_RELEASE, '0, '0, {$urandom, $urandom});
    send_request(OP_CLEAR, '1, $urandom, {$urandom, $urandom});
    drain_replies();
  endtask

  task automatic test_full_table;
    logic [OWNER_W-1:0] owner;
    logic [INODE_W-1:0] last_inode;
    owner = OWNER_W'($urandom);
    last_inode = '0;
    for (int i = 0; i < SLOTS; i++) begin
      last_inode = {28'($urandom_range(0, 32'h0FFF_FFFF)), i[3:0]};
      send_request(OP_INSERT, owner, last_inode, {$urandom, $urandom});
    end
    send_request(OP_INSERT, owner ^ 16'h0001, $urandom, {$urandom, $urandom});
    send_request(OP_LOOKUP, owner, last_inode, {$urandom, $urandom});
    send_request(OP_CLEAR, owner, $urandom, {$urandom, $urandom});
    drain_replies();
  endtask

  task automatic send_pooled_op(input logic [OWNER_W-1:0] owners[4], input int n_owners,
                                input logic [INODE_W-1:0] inodes[6]);
    int roll;
    logic [1:0] op;
    logic [OWNER_W-1:0] owner;
    logic [INODE_W-1:0] inode;
    roll = $urandom_range(0, 99);
    if (roll < 35) op = OP_INSERT;
    else if (roll < 65) op = OP_LOOKUP;
    else if (roll < 92) op = OP_RELEASE;
    else op = OP_CLEAR;
    owner = owners[$urandom_range(0, n_owners - 1)];
    inode = inodes[$urandom_range(0, 5)];
    if ($urandom_range(0, 9) == 0) begin
      owner = OWNER_W'($urandom);
      inode = $urandom;
    end
    send_request(op, owner, inode, {$urandom, $urandom});
  endtask

  task automatic fill_pools(output logic [OWNER_W-1:0] owners[4],
                            output logic [INODE_W-1:0] inodes[6]);
    foreach (owners[i]) owners[i] = OWNER_W'($urandom);
    foreach (inodes[i]) inodes[i] = $urandom;
  endtask

  task automatic test_backpressure;
    logic [OWNER_W-1:0] owners[4];
    logic [INODE_W-1:0] inodes[6];
    fill_pools(owners, inodes);
    gaps_on = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (24) send_pooled_op(owners, 2, inodes);
    drain_replies();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int count, input bit with_gaps);
    logic [OWNER_W-1:0] owners[4];
    logic [INODE_W-1:0] inodes[6];
    int n_owners;
    fill_pools(owners, inodes);
    n_owners = $urandom_range(1, 4);
    gaps_on = with_gaps;
    repeat (count) send_pooled_op(owners, n_owners, inodes);
    drain_replies();
  endtask

  // Receiver: changes its stall rate every so often and honors long hold-offs.
  initial begin
    int mode_left;
    int stall_pct;
    int hold_left;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 40;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  initial begin
    node_reply_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[63:0], '0);
        end else begin
          want = pending_replies.pop_front();
          if (m_axis_tdata[OUT_STAT_LSB +: 2] !== want.status)
            report_mismatch("status", 64'(m_axis_tdata[OUT_STAT_LSB +: 2]),
                            64'(want.status));
          if (m_axis_tdata[OUT_SLOT_LSB +: SLOT_W] !== want.slot)
            report_mismatch("slot_index", 64'(m_axis_tdata[OUT_SLOT_LSB +: SLOT_W]),
                            64'(want.slot));
          if (m_axis_tdata[OUT_PL_LSB +: PORT_PL_W] !== want.payload)
            report_mismatch("payload_out", m_axis_tdata[OUT_PL_LSB +: PORT_PL_W],
                            want.payload);
          if (m_axis_tdata[OUT_FREED_LSB +: FREED_W] !== want.freed)
            report_mismatch("freed_count", 64'(m_axis_tdata[OUT_FREED_LSB +: FREED_W]),
                            64'(want.freed));
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_full_table();
    test_backpressure();
    for (int phase = 0; phase < 4; phase++) begin
      test_random_traffic(150, phase[0]);
    end
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
